// ===== rtl/core/pvm_pkg.sv =====
// pvm_pkg: shared types, request codes and arithmetic helpers for the pcm voice mixer
`timescale 1ns / 1ps

package pvm_pkg;

    // default configuration
    localparam int VOICES_DEF       = 8;
    localparam int SAMPLE_WORDS_DEF = 65536;

    // mix accumulator holds up to thirty-two full-scale voices
    localparam int ACC_W = 21;

    // request codes
    localparam logic [2:0] REQ_LOAD      = 3'd0;
    localparam logic [2:0] REQ_PLAY_FREE = 3'd1;
    localparam logic [2:0] REQ_PLAY_AT   = 3'd2;
    localparam logic [2:0] REQ_STOP      = 3'd3;
    localparam logic [2:0] REQ_MIX       = 3'd4;

    // status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_VOC = 1'b1;

    // saturation limits
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sh8000);

    // volume at or above this is unity gain
    localparam logic [7:0] VOL_UNITY = 8'd128;

    // input item
    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         voice;
        logic [15:0]        address;
        logic signed [15:0] sample_word;
        logic [17:0]        length_bytes;
        logic [7:0]         volume;
        logic               stereo;
    } t_req_item;

    // result item
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [3:0]         voice_used;
        logic               status;
        logic [7:0]         active_mask;
        logic [3:0]         playing_count;
        logic               last;
    } t_res_item;

    // one voice memory entry
    typedef struct packed {
        logic [15:0] addr;
        logic [17:0] rem;
        logic [7:0]  vol;
        logic        st;
    } t_voice;

    // address modulo memory depth, restoring steps (quotient fits in 8 bits)
    function automatic logic [15:0] word_mod(input logic [15:0] a, input logic [16:0] n);
        logic [23:0] r;
        r = {8'b0, a};
        for (int k = 7; k >= 0; k--) begin
            if (r >= ({7'b0, n} << k)) begin
                r = r - ({7'b0, n} << k);
            end
        end
        return r[15:0];
    endfunction

    // trunc(vol * s / 128) below unity, else s
    function automatic logic signed [15:0] scale_smp(input logic signed [15:0] s,
                                                     input logic [7:0] vol);
        logic signed [24:0] p;
        logic signed [24:0] q;
        p = $signed({1'b0, vol}) * s;
        q = p[24] ? p + 25'sd127 : p;
        if (vol < VOL_UNITY) begin
            return q[22:7];
        end
        return s;
    endfunction

    // clamp a mix sum to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
        if (x > SAT_MAX) begin
            return 16'sh7FFF;
        end
        if (x < SAT_MIN) begin
            return -16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

// ===== rtl/core/pvm_req_if.sv =====
// pvm_req_if: request channel with valid, ready and the request item
`timescale 1ns / 1ps

interface pvm_req_if;
    import pvm_pkg::*;

    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pvm_res_if.sv =====
// pvm_res_if: result channel with valid, ready and the result item
`timescale 1ns / 1ps

interface pvm_res_if;
    import pvm_pkg::*;

    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pcm_voice_mixer.sv =====
// pcm_voice_mixer: multi-voice pcm mixer with sample memory and voice state memory
// Load, play and stop requests finish in the transfer cycle: result valid in the next cycle.
// A mix request walks the voices through the voice memory: each voice is checked, an active
// voice's state is read and its sample or sample pair fetched, then the mix is emitted.
// One request at a time; the next is taken once the result register can be refilled.
// Synchronous reset clears all voices, the output valid flag and halve_rate, and needs no
// clearing pass; sample memory content is undefined until loaded.
`timescale 1ns / 1ps

module pcm_voice_mixer #(
    parameter int VOICES       = pvm_pkg::VOICES_DEF,
    parameter int SAMPLE_WORDS = pvm_pkg::SAMPLE_WORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_data,
    pvm_req_if.sink      i_req,
    pvm_res_if.source    o_res
);
    import pvm_pkg::*;

    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int VIW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW     = $clog2(VOICES + 1);
    localparam int MASK_V = (VOICES < 8) ? VOICES : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX_RD,
        S_MIX_VOICE,
        S_SAMP,
        S_EMIT,
        S_DUP
    } t_state;

    // registers
    t_state                    r_state, n_state;
    logic [VOICES-1:0]         r_active, n_active;
    logic [CW-1:0]             r_vidx, n_vidx;
    logic [15:0]               r_addr, n_addr;
    logic [17:0]               r_rem, n_rem;
    logic [7:0]                r_vol, n_vol;
    logic                      r_st, n_st;
    logic                      r_side, n_side;
    logic signed [15:0]        r_left, n_left;
    logic signed [ACC_W-1:0]   r_acc_l, n_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r, n_acc_r;
    logic                      r_halve, n_halve;
    logic                      r_out_valid, n_out_valid;
    t_res_item                 r_out, n_out;

    // memories
    logic [15:0]               r_smp_mem [SAMPLE_WORDS];
    logic signed [15:0]        r_smp_rdata;
    t_voice                    r_voc_mem [VOICES];
    t_voice                    r_vm_rdata;

    // memory port controls
    logic                      smp_we, smp_re;
    logic [AW-1:0]             smp_waddr, smp_raddr;
    logic                      vm_we, vm_re;
    logic [VIW-1:0]            vm_widx, vm_ridx;
    t_voice                    vm_wdata;

    // handshake and helpers
    logic                      out_free;
    logic                      accept;
    logic                      voc_bad;
    logic [VIW-1:0]            free_idx;
    logic [VIW-1:0]            cur_idx;
    logic [VIW-1:0]            sel_idx;
    logic signed [15:0]        sc;
    logic signed [15:0]        mix_l, mix_r;
    logic signed [18:0]        cnt;
    logic [4:0]                act_cnt;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign voc_bad = ({1'b0, i_req.data.voice} >= 5'(VOICES));
    assign cur_idx = r_vidx[VIW-1:0];
    assign sel_idx = i_req.data.voice[VIW-1:0];
    assign sc      = scale_smp(r_smp_rdata, r_vol);
    assign mix_l   = sat16(r_acc_l);
    assign mix_r   = sat16(r_acc_r);
    assign cnt     = $signed({1'b0, r_rem}) - (r_st ? 19'sd4 : 19'sd2);

    // lowest free voice, voice 0 when all are busy
    always_comb begin
        free_idx = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                free_idx = VIW'(v);
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_vidx      = r_vidx;
        n_addr      = r_addr;
        n_rem       = r_rem;
        n_vol       = r_vol;
        n_st        = r_st;
        n_side      = r_side;
        n_left      = r_left;
        n_acc_l     = r_acc_l;
        n_acc_r     = r_acc_r;
        n_halve     = i_cfg_we ? i_cfg_data : r_halve;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        smp_we      = 1'b0;
        smp_waddr   = word_mod(i_req.data.address, 17'(SAMPLE_WORDS))[AW-1:0];
        smp_re      = 1'b0;
        smp_raddr   = '0;
        vm_we       = 1'b0;
        vm_widx     = '0;
        vm_wdata    = '0;
        vm_re       = 1'b0;
        vm_ridx     = cur_idx;
        act_cnt     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    vm_wdata    = '{addr: i_req.data.address, rem: i_req.data.length_bytes,
                                    vol: i_req.data.volume, st: i_req.data.stereo};
                    unique case (i_req.data.req_type)
                        REQ_LOAD: begin
                            smp_we = 1'b1;
                        end
                        REQ_PLAY_FREE: begin
                            n_active[free_idx] = 1'b1;
                            vm_we              = 1'b1;
                            vm_widx            = free_idx;
                            n_out.voice_used   = 4'(free_idx);
                        end
                        REQ_PLAY_AT, REQ_STOP: begin
                            if (voc_bad) begin
                                n_out.status = ST_BAD_VOC;
                            end else begin
                                n_out.voice_used = i_req.data.voice;
                                if (i_req.data.req_type == REQ_PLAY_AT) begin
                                    n_active[sel_idx] = 1'b1;
                                    vm_we             = 1'b1;
                                    vm_widx           = sel_idx;
                                end else begin
                                    n_active[sel_idx] = 1'b0;
                                end
                            end
                        end
                        REQ_MIX: begin
                            n_out_valid = r_out_valid && !o_res.ready;
                            n_out       = r_out;
                            n_state     = S_MIX_RD;
                            n_vidx      = '0;
                            n_acc_l     = '0;
                            n_acc_r     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MIX_RD: begin
                if (r_vidx == CW'(VOICES)) begin
                    n_state = S_EMIT;
                end else if (r_active[cur_idx]) begin
                    vm_re   = 1'b1;
                    n_state = S_MIX_VOICE;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end
            S_MIX_VOICE: begin
                // empty voice ends silently, else fetch its first sample
                if (r_vm_rdata.rem == '0) begin
                    n_active[cur_idx] = 1'b0;
                    n_vidx            = r_vidx + 1'b1;
                    n_state           = S_MIX_RD;
                end else begin
                    smp_re    = 1'b1;
                    smp_raddr = word_mod(r_vm_rdata.addr, 17'(SAMPLE_WORDS))[AW-1:0];
                    n_addr    = r_vm_rdata.addr + 16'd1;
                    n_rem     = r_vm_rdata.rem;
                    n_vol     = r_vm_rdata.vol;
                    n_st      = r_vm_rdata.st;
                    n_side    = 1'b0;
                    n_state   = S_SAMP;
                end
            end
            S_SAMP: begin
                if (!r_side && r_st) begin
                    // stereo: keep left, fetch right
                    n_left    = sc;
                    n_side    = 1'b1;
                    smp_re    = 1'b1;
                    smp_raddr = word_mod(r_addr, 17'(SAMPLE_WORDS))[AW-1:0];
                    n_addr    = r_addr + 16'd1;
                end else begin
                    n_acc_l = r_acc_l + ACC_W'(r_side ? r_left : sc);
                    n_acc_r = r_acc_r + ACC_W'(sc);
                    if (cnt <= 19'sd0) begin
                        n_active[cur_idx] = 1'b0;
                    end else begin
                        vm_we    = 1'b1;
                        vm_widx  = cur_idx;
                        vm_wdata = '{addr: r_addr, rem: cnt[17:0], vol: r_vol, st: r_st};
                    end
                    n_vidx  = r_vidx + 1'b1;
                    n_state = S_MIX_RD;
                end
            end
            S_EMIT, S_DUP: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.left_out  = mix_l;
                    n_out.right_out = mix_r;
                    n_out.last      = (r_state == S_DUP) || !r_halve;
                    n_state         = (r_state == S_EMIT && r_halve) ? S_DUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // voice summary after this request
        for (int v = 0; v < MASK_V; v++) begin
            if (n_active[v] && n_out_valid && !(r_out_valid && !o_res.ready)) begin
                n_out.active_mask[v] = 1'b1;
            end
        end
        for (int v = 0; v < VOICES; v++) begin
            act_cnt = act_cnt + 5'(n_active[v]);
        end
        if (n_out_valid && !(r_out_valid && !o_res.ready)) begin
            n_out.playing_count = (act_cnt > 5'd15) ? 4'd15 : act_cnt[3:0];
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_vidx      <= '0;
            r_halve     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_vidx      <= n_vidx;
            r_halve     <= n_halve;
            r_out_valid <= n_out_valid;
        end
        r_addr  <= n_addr;
        r_rem   <= n_rem;
        r_vol   <= n_vol;
        r_st    <= n_st;
        r_side  <= n_side;
        r_left  <= n_left;
        r_acc_l <= n_acc_l;
        r_acc_r <= n_acc_r;
        r_out   <= n_out;
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_smp_mem[smp_waddr] <= i_req.data.sample_word;
        end
        if (smp_re) begin
            r_smp_rdata <= r_smp_mem[smp_raddr];
        end
    end

    // voice state memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            r_voc_mem[vm_widx] <= vm_wdata;
        end
        if (vm_re) begin
            r_vm_rdata <= r_voc_mem[vm_ridx];
        end
    end

`ifndef SYNTH
    // voice walk never passes the voice count
    a_vidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vidx <= CW'(VOICES))
        else $error("voice index out of range");

    // a non-mix request leaves a final result in the output register
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.data.req_type != REQ_MIX) |=> (r_out_valid && r_out.last))
        else $error("non-mix request gave no result");

    // a non-final result only appears with halve_rate set
    a_dup_only_halved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.last) |-> r_halve)
        else $error("non-final result without halve_rate");

    // sample data is consumed only right after a sample read
    a_samp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAMP) |-> $past(smp_re))
        else $error("sample used without a read");

    // a walk entered from idle starts at voice zero
    a_mix_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_IDLE && r_state == S_MIX_RD) |-> r_vidx == '0)
        else $error("mix walk did not start at voice zero");
`endif

endmodule

// ===== sim/pcm_voice_mixer_test.sv =====
// pcm_voice_mixer_test: self-checking testbench with its own mixer predictor and random traffic
`timescale 1ns / 1ps

module pcm_voice_mixer_test;
    import pvm_pkg::*;

    localparam int NV          = VOICES_DEF;
    localparam int MEM_WORDS   = SAMPLE_WORDS_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    // request codes the block does not define
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    pvm_req_if req_ch ();
    pvm_res_if res_ch ();

    pcm_voice_mixer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // predicted mixer state
    logic [15:0] word_mem [MEM_WORDS];
    bit          word_set [MEM_WORDS];
    bit          vc_on    [NV];
    logic [15:0] vc_addr  [NV];
    logic [17:0] vc_left  [NV];
    logic [7:0]  vc_vol   [NV];
    bit          vc_st    [NV];
    bit          halve_m;

    t_res_item   owed_results [$];
    t_res_item   owed_head;
    int          err_count    = 0;
    int          quiet_cycles = 0;
    int          rx_stall     = 0;
    int          rx_hold_req  = 0;
    int          tx_gap_pct   = 0;
    int          rx_gap_pct   = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 12);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic void voice_clear(int v);
        vc_on[v]   = 1'b0;
        vc_addr[v] = '0;
        vc_left[v] = '0;
        vc_vol[v]  = '0;
        vc_st[v]   = 1'b0;
    endfunction

    function automatic void voice_start(int v, t_req_item it);
        vc_on[v]   = 1'b1;
        vc_addr[v] = it.address;
        vc_left[v] = it.length_bytes;
        vc_vol[v]  = it.volume;
        vc_st[v]   = it.stereo;
    endfunction

    // next sample of a voice, scaled when below unity gain
    function automatic int voice_fetch(int v);
        int s;
        s = int'($signed(word_mem[int'(vc_addr[v]) % MEM_WORDS]));
        vc_addr[v] = vc_addr[v] + 16'd1;
        if (vc_vol[v] < VOL_UNITY) begin
            s = (int'(vc_vol[v]) * s) / 128;
        end
        return s;
    endfunction

    function automatic logic signed [15:0] clamp16(int x);
        if (x > 32767) begin
            return 16'sh7FFF;
        end
        if (x < -32768) begin
            return 16'sh8000;
        end
        return 16'(x);
    endfunction

    // apply one accepted request and queue the results it owes
    function automatic void mixer_apply(t_req_item it);
        int         sum_l, sum_r, cnt, l, r, pick, n_out, v, k;
        logic [3:0] used;
        logic       st;
        t_res_item  res;
        sum_l = 0;
        sum_r = 0;
        used  = '0;
        st    = ST_OK;
        n_out = 1;
        case (it.req_type)
            REQ_LOAD: begin
                word_mem[int'(it.address) % MEM_WORDS] = it.sample_word;
                word_set[int'(it.address) % MEM_WORDS] = 1'b1;
            end
            REQ_PLAY_FREE: begin
                pick = 0;
                for (v = NV - 1; v >= 0; v--) begin
                    if (!vc_on[v]) begin
                        pick = v;
                    end
                end
                voice_start(pick, it);
                used = 4'(pick);
            end
            REQ_PLAY_AT, REQ_STOP: begin
                if (int'(it.voice) >= NV) begin
                    st = ST_BAD_VOC;
                end else begin
                    if (it.req_type == REQ_PLAY_AT) begin
                        voice_start(it.voice, it);
                    end else begin
                        voice_clear(it.voice);
                    end
                    used = it.voice;
                end
            end
            REQ_MIX: begin
                for (v = 0; v < NV; v++) begin
                    if (vc_on[v]) begin
                        cnt = int'(vc_left[v]);
                        if (cnt <= 0) begin
                            voice_clear(v);
                        end else begin
                            l = voice_fetch(v);
                            cnt -= 2;
                            if (vc_st[v]) begin
                                r = voice_fetch(v);
                                cnt -= 2;
                            end else begin
                                r = l;
                            end
                            if (cnt <= 0) begin
                                voice_clear(v);
                            end else begin
                                vc_left[v] = 18'(cnt);
                            end
                            sum_l += l;
                            sum_r += r;
                        end
                    end
                end
                if (halve_m) begin
                    n_out = 2;
                end
            end
            default: ;
        endcase

        res.left_out      = clamp16(sum_l);
        res.right_out     = clamp16(sum_r);
        res.voice_used    = used;
        res.status        = st;
        res.active_mask   = '0;
        res.playing_count = '0;
        for (v = 0; v < NV; v++) begin
            if (vc_on[v]) begin
                if (v < 8) begin
                    res.active_mask[v] = 1'b1;
                end
                if (res.playing_count < 4'd15) begin
                    res.playing_count++;
                end
            end
        end
        for (k = 0; k < n_out; k++) begin
            res.last = (k == n_out - 1);
            owed_results.push_back(res);
        end
    endfunction

    function automatic void check_field(string fld, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", fld, want, got);
            err_count++;
        end
    endfunction

    // compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: left %0d right %0d",
                       res_ch.data.left_out, res_ch.data.right_out);
                err_count++;
            end else begin
                owed_head = owed_results.pop_front();
                check_field("left_out", owed_head.left_out, res_ch.data.left_out);
                check_field("right_out", owed_head.right_out, res_ch.data.right_out);
                check_field("voice_used", owed_head.voice_used, res_ch.data.voice_used);
                check_field("status", owed_head.status, res_ch.data.status);
                check_field("active_mask", owed_head.active_mask, res_ch.data.active_mask);
                check_field("playing_count", owed_head.playing_count,
                            res_ch.data.playing_count);
                check_field("last", owed_head.last, res_ch.data.last);
            end
        end
    end

    // result ready with random stalls and requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (rx_hold_req != 0) begin
                rx_stall = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_stall == 0) begin
                rx_stall = pick_gap(rx_gap_pct);
            end
            if (rx_stall > 0) begin
                res_ch.ready <= 1'b0;
                rx_stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("pcm_voice_mixer_test: errors");
            $finish;
        end
    end

    function automatic logic [15:0] rand_addr();
        case ($urandom_range(4))
            0, 1, 2: return 16'($urandom_range(255));
            3:       return 16'($urandom_range(65535, 65280));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // request with random fields, lengths mostly short
    function automatic t_req_item rand_item(logic [2:0] kind);
        t_req_item it;
        it.req_type = kind;
        if ($urandom_range(4) == 0) begin
            it.voice = 4'($urandom_range(15, NV));
        end else begin
            it.voice = 4'($urandom_range(NV - 1));
        end
        it.address     = rand_addr();
        it.sample_word = rand_word();
        case ($urandom_range(9))
            0: it.length_bytes = 18'($urandom_range(131072));
            1: begin
                case ($urandom_range(2))
                    0:       it.length_bytes = 18'd0;
                    1:       it.length_bytes = 18'd1;
                    default: it.length_bytes = 18'd131072;
                endcase
            end
            default: it.length_bytes = 18'($urandom_range(64));
        endcase
        case ($urandom_range(7))
            0:       it.volume = 8'd0;
            1:       it.volume = 8'd127;
            2:       it.volume = 8'd128;
            3:       it.volume = 8'd255;
            default: it.volume = 8'($urandom_range(255));
        endcase
        it.stereo = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_req_item req_of(logic [2:0] kind, logic [3:0] vc, logic [15:0] addr,
                                         logic [15:0] word, logic [17:0] len,
                                         logic [7:0] vol, logic st);
        t_req_item it;
        it.req_type     = kind;
        it.voice        = vc;
        it.address      = addr;
        it.sample_word  = word;
        it.length_bytes = len;
        it.volume       = vol;
        it.stereo       = st;
        return it;
    endfunction

    // offer one request after a random gap and wait for its transfer
    task automatic send_req(input t_req_item it);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        mixer_apply(it);
    endtask

    // mix frame, loading first any word an active voice is about to read
    task automatic send_mix();
        t_req_item   ld;
        int          v, n;
        logic [15:0] a;
        for (v = 0; v < NV; v++) begin
            if (vc_on[v] && vc_left[v] != 0) begin
                a = vc_addr[v];
                for (n = 0; n < (vc_st[v] ? 2 : 1); n++) begin
                    if (!word_set[int'(a) % MEM_WORDS]) begin
                        ld = rand_item(REQ_LOAD);
                        ld.address = a;
                        send_req(ld);
                    end
                    a = a + 16'd1;
                end
            end
        end
        send_req(rand_item(REQ_MIX));
    endtask

    // sender idle until every owed result has arrived
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_halve_rate(input logic val);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        halve_m = val;
    endtask

    // weighted random requests; unused codes are not counted
    task automatic run_random(input int n_items);
        int sent, pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_mix();
            end else if (pick < 58) begin
                send_req(rand_item(REQ_LOAD));
            end else if (pick < 72) begin
                send_req(rand_item(REQ_PLAY_FREE));
            end else if (pick < 86) begin
                send_req(rand_item(REQ_PLAY_AT));
            end else if (pick < 97) begin
                send_req(rand_item(REQ_STOP));
            end else begin
                send_req(rand_item(3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST))));
                sent--;
            end
            sent++;
        end
    endtask

    task automatic test_directed_requests();
        int k;
        // full scale words at the bottom, most negative at the top, alternating bit patterns
        send_req(req_of(REQ_LOAD, 4'd0, 16'h0000, 16'h7FFF, 18'd0, 8'd0, 1'b0));
        send_req(req_of(REQ_LOAD, 4'd0, 16'h0001, 16'h7FFF, 18'd0, 8'd0, 1'b0));
        send_req(req_of(REQ_LOAD, 4'd15, 16'hFFFE, 16'h8000, 18'h3FFFF, 8'hFF, 1'b1));
        send_req(req_of(REQ_LOAD, 4'd15, 16'hFFFF, 16'h8000, 18'h3FFFF, 8'hFF, 1'b1));
        send_req(req_of(REQ_LOAD, 4'd5, 16'h5555, 16'hAAAA, 18'h2AAAA, 8'hAA, 1'b1));
        send_req(req_of(REQ_LOAD, 4'd10, 16'hAAAA, 16'h5555, 18'h15555, 8'h55, 1'b0));
        // first free voice, unity gain, odd stereo length, just below unity, zero length
        send_req(req_of(REQ_PLAY_FREE, 4'd0, 16'h0000, 16'h0000, 18'd8, 8'd255, 1'b0));
        send_req(req_of(REQ_PLAY_FREE, 4'd0, 16'h0000, 16'h0000, 18'd5, 8'd128, 1'b1));
        send_req(req_of(REQ_PLAY_AT, 4'd2, 16'h0001, 16'h0000, 18'd2, 8'd127, 1'b0));
        send_req(req_of(REQ_PLAY_AT, 4'd3, 16'h0000, 16'h0000, 18'd0, 8'd255, 1'b0));
        // out of range voice numbers
        send_req(req_of(REQ_PLAY_AT, 4'd15, 16'h0000, 16'h0000, 18'd8, 8'd128, 1'b0));
        send_req(req_of(REQ_STOP, 4'd8, 16'h0000, 16'h0000, 18'd0, 8'd0, 1'b0));
        // positive clipping
        send_mix();
        send_req(req_of(REQ_STOP, 4'd0, 16'h0000, 16'h0000, 18'd0, 8'd0, 1'b0));
        send_req(req_of(REQ_STOP, 4'd1, 16'h0000, 16'h0000, 18'd0, 8'd0, 1'b0));
        // voices near the top of memory run across the address wrap
        send_req(req_of(REQ_PLAY_AT, 4'd4, 16'hFFFE, 16'h0000, 18'd131072, 8'd255, 1'b1));
        send_req(req_of(REQ_PLAY_AT, 4'd5, 16'hFFFE, 16'h0000, 18'd3, 8'd128, 1'b0));
        send_req(req_of(REQ_PLAY_AT, 4'd6, 16'hFFFF, 16'h0000, 18'd4, 8'd0, 1'b1));
        // negative clipping
        send_mix();
        for (k = REQ_UNUSED_FIRST; k <= REQ_UNUSED_LAST; k++) begin
            send_req(rand_item(3'(k)));
        end
        send_mix();
    endtask

    // all voices busy: play first free falls back to voice 0
    task automatic test_no_free_voice();
        t_req_item it;
        int        v, busy;
        busy = 0;
        while (busy < NV) begin
            it = rand_item(REQ_PLAY_FREE);
            it.length_bytes = 18'd4096;
            send_req(it);
            busy = 0;
            for (v = 0; v < NV; v++) begin
                busy += vc_on[v];
            end
        end
        send_req(rand_item(REQ_PLAY_FREE));
        send_mix();
    endtask

    task automatic test_random_traffic();
        set_halve_rate(1'b1);
        tx_gap_pct = 30;
        rx_gap_pct = 30;
        run_random(400);
        // stretch with no idling on either side
        set_halve_rate(1'b0);
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        run_random(300);
        set_halve_rate(1'b1);
        tx_gap_pct = 15;
        rx_gap_pct = 50;
        run_random(400);
        set_halve_rate(1'b0);
        tx_gap_pct = 50;
        rx_gap_pct = 10;
        run_random(400);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_backpressure();
        tx_gap_pct  = 0;
        rx_gap_pct  = 20;
        rx_hold_req = HOLD_CYCLES;
        run_random(40);
    endtask

    // sender stops until all results are in, then resumes
    task automatic test_sender_pause();
        tx_gap_pct = 20;
        set_halve_rate(1'b1);
        run_random(60);
        wait_drained();
        run_random(60);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        tx_gap_pct   = 20;
        rx_gap_pct   = 20;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_halve_rate(1'b0);
        test_directed_requests();
        set_halve_rate(1'b1);
        test_no_free_voice();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("pcm_voice_mixer_test: clean");
        end else begin
            $display("pcm_voice_mixer_test: errors");
        end
        $finish;
    end

endmodule
